// ===== src/hgn_pkg.sv =====
// hgn_pkg: shared types and constants for the heightfield grid normal block.
// Used by the controller, the datapath, the channel interfaces and the top level.
package hgn_pkg;

	localparam int VTX_W  = 24;
	localparam int NRM_W  = 16;
	localparam int IDX_W  = 16;
	localparam int SIDE_W = 8;
	localparam logic [SIDE_W-1:0] SIDE_RESET = 8'd64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_MUL,
		ST_MAG,
		ST_SHF,
		ST_SQ,
		ST_SQRT,
		ST_DIVL,
		ST_DIV,
		ST_OUT1,
		ST_OUT2
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_a;
		logic rd_an;
		logic commit;
		logic mul_step;
		logic mag;
		logic shf_step;
		logic sq_step;
		logic sqrt_step;
		logic div_load;
		logic div_step;
		logic sel_second;
	} cmd_t;

	typedef struct packed {
		logic emit_first;
		logic interior;
		logic second;
		logic mul_last;
		logic is_zero;
		logic shf_done;
		logic sq_last;
		logic sqrt_last;
		logic div_bit_last;
		logic div_comp_last;
	} sts_t;

endpackage

// ===== src/hgn_vertex_if.sv =====
// hgn_vertex_if: valid/ready channel carrying one grid vertex per transaction.
// Depends on hgn_pkg for field widths.
interface hgn_vertex_if;
	logic                             valid;
	logic                             ready;
	logic signed [hgn_pkg::VTX_W-1:0] vertex_x;
	logic signed [hgn_pkg::VTX_W-1:0] vertex_y;
	logic signed [hgn_pkg::VTX_W-1:0] vertex_z;

	modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
	modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

// ===== src/hgn_normal_if.sv =====
// hgn_normal_if: valid/ready channel carrying one vertex normal per transaction.
// Depends on hgn_pkg for field widths.
interface hgn_normal_if;
	logic                             valid;
	logic                             ready;
	logic signed [hgn_pkg::NRM_W-1:0] normal_x;
	logic signed [hgn_pkg::NRM_W-1:0] normal_y;
	logic signed [hgn_pkg::NRM_W-1:0] normal_z;
	logic        [hgn_pkg::IDX_W-1:0] vertex_index;
	logic                             last_of_item;

	modport source (output valid, normal_x, normal_y, normal_z, vertex_index, last_of_item,
		input ready);
	modport sink   (input valid, normal_x, normal_y, normal_z, vertex_index, last_of_item,
		output ready);
endinterface

// ===== src/heightfield_grid_normals_top.sv =====
// heightfield_grid_normals_top: streaming per-vertex normals of a square height grid.
// Depends on hgn_pkg, hgn_vertex_if, hgn_normal_if, hgn_ctrl, hgn_dp, hgn_ram.
//
// Usage:
//   vertices: one vertex (Q15.8 x,y,z) per transaction, row-major over a grid of
//     (grid_side+1)^2 vertices. From the second row on, each vertex yields the
//     normal of the vertex one row above; on the last row a second +Z normal for
//     the vertex itself follows, flagged by last_of_item.
//   normals: Q1.14 normal plus row-major vertex index per transaction.
//   cfg_we/cfg_wdata: writes grid_side (reset 64) and restarts at row 0, column 0;
//     write only while idle.
// Sequence: one vertex at a time. A first-row vertex passes RD0, RD1 and RD2 and yields
//   no normal. A border normal is offered after RD0, RD1 and RD2. An interior normal
//   passes the shared cross-product multiplier, magnitude, the right-shift loop,
//   three squares, a 31-step square root and three bit-serial divisions of
//   31+NORMAL_FRAC_BITS steps each, each after a load step, and is offered at Q1.14;
//   a zero cross product skips from the shift loop to a +Z normal.
//   The next vertex can be taken in the cycle after the final normal is accepted.
// Reset clears the controller and the grid counters; line buffers hold garbage
//   until written, which no output depends on.
// A stalled receiver holds the result; no new vertex is taken until all results
//   of the current one are delivered.
module heightfield_grid_normals_top #(
	parameter int LINE_DEPTH       = 256,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hgn_vertex_if.sink                  vertices,
	hgn_normal_if.source                normals,
	input  logic                        cfg_we,
	input  logic [hgn_pkg::SIDE_W-1:0]  cfg_wdata
);
	hgn_pkg::cmd_t cmd;
	hgn_pkg::sts_t sts;

	hgn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vertices.valid),
		.in_ready  (vertices.ready),
		.out_valid (normals.valid),
		.out_ready (normals.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	hgn_dp #(
		.LINE_DEPTH       (LINE_DEPTH),
		.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.vx        (vertices.vertex_x),
		.vy        (vertices.vertex_y),
		.vz        (vertices.vertex_z),
		.cmd       (cmd),
		.sts       (sts),
		.nrm_x     (normals.normal_x),
		.nrm_y     (normals.normal_y),
		.nrm_z     (normals.normal_z),
		.nrm_idx   (normals.vertex_index),
		.nrm_last  (normals.last_of_item)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(vertices.ready && normals.valid))
		else $error("input taken while a result is pending");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(normals.valid && normals.ready && !normals.last_of_item) |=>
		(normals.valid && normals.last_of_item))
		else $error("second result missing");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(normals.valid && normals.ready && normals.last_of_item) |=> vertices.ready)
		else $error("block not idle after final result");
endmodule

// ===== src/hgn_ram.sv =====
// hgn_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module hgn_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/hgn_ctrl.sv =====
// hgn_ctrl: sequencing state machine for the grid normal block.
// Depends on hgn_pkg; drives hgn_dp through cmd_t and reads sts_t.
module hgn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output hgn_pkg::cmd_t cmd,
	input  hgn_pkg::sts_t sts
);
	hgn_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hgn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			hgn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = hgn_pkg::ST_RD0;
				end
			end
			hgn_pkg::ST_RD0: begin
				cmd.rd_a = 1'b1;
				state_d  = hgn_pkg::ST_RD1;
			end
			hgn_pkg::ST_RD1: begin
				cmd.rd_an = 1'b1;
				state_d   = hgn_pkg::ST_RD2;
			end
			hgn_pkg::ST_RD2: begin
				cmd.commit = 1'b1;
				if (!sts.emit_first) begin
					state_d = hgn_pkg::ST_IDLE;
				end else if (sts.interior) begin
					state_d = hgn_pkg::ST_MUL;
				end else begin
					state_d = hgn_pkg::ST_OUT1;
				end
			end
			hgn_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) begin
					state_d = hgn_pkg::ST_MAG;
				end
			end
			hgn_pkg::ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = hgn_pkg::ST_SHF;
			end
			hgn_pkg::ST_SHF: begin
				if (sts.is_zero) begin
					state_d = hgn_pkg::ST_OUT1;
				end else if (sts.shf_done) begin
					state_d = hgn_pkg::ST_SQ;
				end else begin
					cmd.shf_step = 1'b1;
				end
			end
			hgn_pkg::ST_SQ: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_last) begin
					state_d = hgn_pkg::ST_SQRT;
				end
			end
			hgn_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_last) begin
					state_d = hgn_pkg::ST_DIVL;
				end
			end
			hgn_pkg::ST_DIVL: begin
				cmd.div_load = 1'b1;
				state_d      = hgn_pkg::ST_DIV;
			end
			hgn_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_bit_last) begin
					state_d = sts.div_comp_last ? hgn_pkg::ST_OUT1 : hgn_pkg::ST_DIVL;
				end
			end
			hgn_pkg::ST_OUT1: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = sts.second ? hgn_pkg::ST_OUT2 : hgn_pkg::ST_IDLE;
				end
			end
			hgn_pkg::ST_OUT2: begin
				out_valid      = 1'b1;
				cmd.sel_second = 1'b1;
				if (out_ready) begin
					state_d = hgn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hgn_pkg::ST_IDLE;
			end
		endcase
	end
endmodule

// ===== src/hgn_dp.sv =====
// hgn_dp: line buffers, grid counters, cross product, iterative sqrt and divider.
// Depends on hgn_pkg and hgn_ram; controlled by hgn_ctrl.
module hgn_dp #(
	parameter int LINE_DEPTH       = 256,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic        [hgn_pkg::SIDE_W-1:0]  cfg_wdata,
	input  logic signed [hgn_pkg::VTX_W-1:0]   vx,
	input  logic signed [hgn_pkg::VTX_W-1:0]   vy,
	input  logic signed [hgn_pkg::VTX_W-1:0]   vz,
	input  hgn_pkg::cmd_t                      cmd,
	output hgn_pkg::sts_t                      sts,
	output logic signed [hgn_pkg::NRM_W-1:0]   nrm_x,
	output logic signed [hgn_pkg::NRM_W-1:0]   nrm_y,
	output logic signed [hgn_pkg::NRM_W-1:0]   nrm_z,
	output logic        [hgn_pkg::IDX_W-1:0]   nrm_idx,
	output logic                               nrm_last
);
	localparam int AW   = $clog2(LINE_DEPTH);
	localparam int VW   = hgn_pkg::VTX_W;
	localparam int RW   = 3 * VW;
	localparam int DW   = VW + 1;
	localparam int PW   = 2 * DW;
	localparam int CWID = PW + 1;
	localparam int NW   = 31 + NORMAL_FRAC_BITS;
	localparam int CW   = $clog2(NW);
	localparam int SW   = hgn_pkg::SIDE_W;
	localparam int OW   = hgn_pkg::NRM_W;
	localparam logic [OW-1:0] ZPLUS = OW'(64'd1 << NORMAL_FRAC_BITS);

	// grid position and configuration
	logic [SW-1:0] gs_q, row_q, col_q;
	logic [AW-1:0] addr_q, addr_n, raddr;
	logic [SW-1:0] side;

	// per-item registers
	logic signed [VW-1:0] v_q [3];
	logic emit_first_q, interior_q, second_q;
	logic [hgn_pkg::IDX_W-1:0] idx1_q, idx2_q;
	logic [RW-1:0] old_rd, new_rd, ox_q, nx_q, held_q;
	logic signed [DW-1:0] dr_q [3];
	logic signed [DW-1:0] dc_q [3];

	// arithmetic
	logic [CW-1:0] cnt_q;
	logic signed [PW-1:0] prod_q;
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [CWID-1:0] c_q [3];
	logic [CWID-1:0] m_q [3];
	logic [2:0] sgn_q;
	logic [59:0] sq_q;
	logic [61:0] sum_q;
	logic [33:0] rem_q, rs_sq, trial;
	logic [30:0] root_q;
	logic [31:0] rem_d_q, rs_d;
	logic [NW-1:0] num_q, qv;
	logic [1:0] comp_q;
	logic [29:0] m_sel;
	logic qbit;
	logic [OW-1:0] q16, qres;
	logic [OW-1:0] res_q [3];
	logic [2*SW:0] base;
	logic [hgn_pkg::IDX_W-1:0] step_w;

	assign side   = (gs_q == '0) ? SW'(1) : gs_q;
	assign addr_n = (addr_q == AW'(LINE_DEPTH - 1)) ? '0 : addr_q + AW'(1);
	assign raddr  = cmd.rd_an ? addr_n : addr_q;

	hgn_ram #(.WIDTH(RW), .DEPTH(LINE_DEPTH)) u_older (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (addr_q),
		.wdata (nx_q),
		.raddr (raddr),
		.rdata (old_rd)
	);

	hgn_ram #(.WIDTH(RW), .DEPTH(LINE_DEPTH)) u_newer (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (addr_q),
		.wdata ({v_q[2], v_q[1], v_q[0]}),
		.raddr (raddr),
		.rdata (new_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q   <= hgn_pkg::SIDE_RESET;
			row_q  <= '0;
			col_q  <= '0;
			addr_q <= '0;
		end else if (cfg_we) begin
			gs_q   <= cfg_wdata;
			row_q  <= '0;
			col_q  <= '0;
			addr_q <= '0;
		end else if (cmd.commit) begin
			if (col_q >= side) begin
				col_q  <= '0;
				addr_q <= '0;
				row_q  <= (row_q >= side) ? '0 : row_q + SW'(1);
			end else begin
				col_q  <= col_q + SW'(1);
				addr_q <= addr_n;
			end
		end
	end

	assign base   = (2*SW+1)'(({1'b0, side} + (SW+1)'(1)) * row_q);
	assign step_w = hgn_pkg::IDX_W'({1'b0, side} + (SW+1)'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q[0]       <= vx;
			v_q[1]       <= vy;
			v_q[2]       <= vz;
			emit_first_q <= (row_q >= SW'(1));
			second_q     <= (row_q == side);
			interior_q   <= (row_q >= SW'(2)) && (row_q <= side) &&
				(col_q >= SW'(1)) && (col_q < side);
			idx2_q       <= hgn_pkg::IDX_W'(base) + hgn_pkg::IDX_W'(col_q);
			idx1_q       <= hgn_pkg::IDX_W'(base) - step_w + hgn_pkg::IDX_W'(col_q);
		end
		if (cmd.rd_an) begin
			ox_q <= old_rd;
			nx_q <= new_rd;
		end
		if (cmd.commit) begin
			for (int k = 0; k < 3; k++) begin
				dr_q[k] <= DW'(v_q[k]) - DW'($signed(ox_q[k*VW +: VW]));
				dc_q[k] <= DW'($signed(new_rd[k*VW +: VW])) - DW'($signed(held_q[k*VW +: VW]));
			end
			held_q <= nx_q;
		end
	end

	// cross product: one multiplier, six products
	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin mul_a = dr_q[1]; mul_b = dc_q[2]; end
			3'd1: begin mul_a = dr_q[2]; mul_b = dc_q[1]; end
			3'd2: begin mul_a = dr_q[2]; mul_b = dc_q[0]; end
			3'd3: begin mul_a = dr_q[0]; mul_b = dc_q[2]; end
			3'd4: begin mul_a = dr_q[0]; mul_b = dc_q[1]; end
			default: begin mul_a = dr_q[1]; mul_b = dc_q[0]; end
		endcase
	end

	assign rs_sq = {rem_q[31:0], sum_q[61:60]};
	assign trial = {1'b0, root_q, 2'b01};

	always_comb begin
		case (comp_q)
			2'd0:    m_sel = m_q[0][29:0];
			2'd1:    m_sel = m_q[1][29:0];
			default: m_sel = m_q[2][29:0];
		endcase
	end

	assign rs_d = {rem_d_q[30:0], num_q[NW-1]};
	assign qbit = (rs_d >= {1'b0, root_q});
	assign qv   = {num_q[NW-2:0], qbit};
	assign q16  = qv[OW-1:0];
	assign qres = sgn_q[comp_q] ? (OW'(0) - q16) : q16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if ((cmd.mul_step && cnt_q == CW'(6)) ||
				(cmd.sq_step && cnt_q == CW'(3)) ||
				(cmd.sqrt_step && cnt_q == CW'(30)) ||
				(cmd.div_step && cnt_q == CW'(NW - 1)) || cmd.commit) begin
			cnt_q <= '0;
		end else if (cmd.mul_step || cmd.sq_step || cmd.sqrt_step || cmd.div_step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			sum_q     <= '0;
			rem_q     <= '0;
			root_q    <= '0;
			comp_q    <= '0;
			res_q[0]  <= '0;
			res_q[1]  <= '0;
			res_q[2]  <= ZPLUS;
		end
		if (cmd.mul_step) begin
			prod_q <= mul_a * mul_b;
			case (cnt_q[2:0])
				3'd1: c_q[0] <= CWID'(prod_q);
				3'd2: c_q[0] <= c_q[0] - CWID'(prod_q);
				3'd3: c_q[1] <= CWID'(prod_q);
				3'd4: c_q[1] <= c_q[1] - CWID'(prod_q);
				3'd5: c_q[2] <= CWID'(prod_q);
				3'd6: c_q[2] <= c_q[2] - CWID'(prod_q);
				default: ;
			endcase
		end
		if (cmd.mag) begin
			for (int k = 0; k < 3; k++) begin
				m_q[k]   <= c_q[k][CWID-1] ? CWID'(0) - CWID'(c_q[k]) : CWID'(c_q[k]);
				sgn_q[k] <= c_q[k][CWID-1];
			end
		end
		if (cmd.shf_step) begin
			for (int k = 0; k < 3; k++) begin
				m_q[k] <= m_q[k] >> 1;
			end
		end
		if (cmd.sq_step) begin
			sq_q <= m_sel * m_sel;
			if (cnt_q != '0) begin
				sum_q <= sum_q + 62'(sq_q);
			end
			comp_q <= (cnt_q >= CW'(2)) ? 2'd0 : comp_q + 2'd1;
		end
		if (cmd.sqrt_step) begin
			sum_q <= sum_q << 2;
			if (rs_sq >= trial) begin
				rem_q  <= rs_sq - trial;
				root_q <= {root_q[29:0], 1'b1};
			end else begin
				rem_q  <= rs_sq;
				root_q <= {root_q[29:0], 1'b0};
			end
		end
		if (cmd.div_load) begin
			rem_d_q <= '0;
			num_q   <= (NW'(m_sel) << NORMAL_FRAC_BITS) + NW'(root_q >> 1);
		end
		if (cmd.div_step) begin
			num_q   <= qv;
			rem_d_q <= qbit ? rs_d - {1'b0, root_q} : rs_d;
			if (cnt_q == CW'(NW - 1)) begin
				res_q[comp_q] <= qres;
				comp_q        <= comp_q + 2'd1;
			end
		end
	end

	always_comb begin
		sts               = '0;
		sts.emit_first    = emit_first_q;
		sts.interior      = interior_q;
		sts.second        = second_q;
		sts.mul_last      = (cnt_q == CW'(6));
		sts.is_zero       = (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
		sts.shf_done      = (m_q[0][CWID-1:30] == '0) && (m_q[1][CWID-1:30] == '0) &&
			(m_q[2][CWID-1:30] == '0);
		sts.sq_last       = (cnt_q == CW'(3));
		sts.sqrt_last     = (cnt_q == CW'(30));
		sts.div_bit_last  = (cnt_q == CW'(NW - 1));
		sts.div_comp_last = (comp_q == 2'd2);
	end

	assign nrm_x    = cmd.sel_second ? '0 : res_q[0];
	assign nrm_y    = cmd.sel_second ? '0 : res_q[1];
	assign nrm_z    = cmd.sel_second ? ZPLUS : res_q[2];
	assign nrm_idx  = cmd.sel_second ? idx2_q : idx1_q;
	assign nrm_last = cmd.sel_second | ~second_q;
endmodule

// ===== verif/heightfield_grid_normals_top_tb.sv =====
// heightfield_grid_normals_top_tb: self-checking bench for the grid normal block.
// Streams vertex grids of several sizes and checks every normal against a predictor.
// Depends on hgn_pkg, hgn_vertex_if, hgn_normal_if and heightfield_grid_normals_top.
module heightfield_grid_normals_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH   = 256;
	localparam int FRAC         = 14;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int SETTLE       = 20;
	localparam int VMAX         = 8388607;
	localparam int VMIN         = -8388608;

	typedef struct {
		logic [hgn_pkg::NRM_W-1:0] nx;
		logic [hgn_pkg::NRM_W-1:0] ny;
		logic [hgn_pkg::NRM_W-1:0] nz;
		logic [hgn_pkg::IDX_W-1:0] idx;
		logic                      last;
	} normal_t;

	typedef struct {
		bit cfg;
		int x;
		int y;
		int z;
		bit typed;
		int ex;
		int ey;
		int ez;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [hgn_pkg::SIDE_W-1:0] cfg_wdata;

	hgn_vertex_if vertices_ch();
	hgn_normal_if normals_ch();

	heightfield_grid_normals_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.vertices (vertices_ch),
		.normals  (normals_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	int side_reg;
	int older_x [LINE_DEPTH], older_y [LINE_DEPTH], older_z [LINE_DEPTH];
	int newer_x [LINE_DEPTH], newer_y [LINE_DEPTH], newer_z [LINE_DEPTH];
	int held_x, held_y, held_z;
	int row_cnt, col_cnt;

	normal_t pending_normals[$];
	int send_gap_pct;
	int recv_stall_pct;
	int mismatches;
	int normals_seen;
	int vertices_sent;
	int interior_seen;
	int cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void unit_normal(input longint c0, input longint c1, input longint c2,
		output logic [hgn_pkg::NRM_W-1:0] ox, output logic [hgn_pkg::NRM_W-1:0] oy,
		output logic [hgn_pkg::NRM_W-1:0] oz);
		longint unsigned m [3];
		longint c [3];
		longint unsigned mx, sum, v, res, b, q, one;
		int s;
		longint n [3];
		c[0] = c0; c[1] = c1; c[2] = c2;
		one = 64'd1 << FRAC;
		for (int k = 0; k < 3; k++) m[k] = c[k] < 0 ? -c[k] : c[k];
		mx = m[0] > m[1] ? m[0] : m[1];
		mx = mx > m[2] ? mx : m[2];
		if (mx == 0) begin
			ox = '0; oy = '0; oz = one[hgn_pkg::NRM_W-1:0];
			return;
		end
		s = 0;
		while ((mx >> s) >= (64'd1 << 30)) s++;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			m[k] = m[k] >> s;
			sum += m[k] * m[k];
		end
		v = sum; res = 0; b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		for (int k = 0; k < 3; k++) begin
			q = (m[k] * one + res / 2) / res;
			n[k] = c[k] < 0 ? -longint'(q) : longint'(q);
		end
		ox = n[0][hgn_pkg::NRM_W-1:0];
		oy = n[1][hgn_pkg::NRM_W-1:0];
		oz = n[2][hgn_pkg::NRM_W-1:0];
	endfunction

	function automatic void predict_normals(input int vx, input int vy, input int vz);
		int eff, i, j, a, an, r;
		longint dr [3], dc [3];
		normal_t e;
		eff = side_reg == 0 ? 1 : side_reg;
		i = row_cnt; j = col_cnt;
		a = j % LINE_DEPTH; an = (j + 1) % LINE_DEPTH;
		if (i >= 1) begin
			r = i - 1;
			e.idx = hgn_pkg::IDX_W'((eff + 1) * r + j);
			e.last = (i != eff);
			if (r >= 1 && r <= eff - 1 && j >= 1 && j <= eff - 1) begin
				dr[0] = longint'(vx) - older_x[a];
				dr[1] = longint'(vy) - older_y[a];
				dr[2] = longint'(vz) - older_z[a];
				dc[0] = longint'(newer_x[an]) - held_x;
				dc[1] = longint'(newer_y[an]) - held_y;
				dc[2] = longint'(newer_z[an]) - held_z;
				unit_normal(dr[1] * dc[2] - dr[2] * dc[1], dr[2] * dc[0] - dr[0] * dc[2],
					dr[0] * dc[1] - dr[1] * dc[0], e.nx, e.ny, e.nz);
				interior_seen++;
			end else begin
				e.nx = '0; e.ny = '0; e.nz = hgn_pkg::NRM_W'(1 << FRAC);
			end
			pending_normals.push_back(e);
			if (i == eff) begin
				e.nx = '0; e.ny = '0; e.nz = hgn_pkg::NRM_W'(1 << FRAC);
				e.idx = hgn_pkg::IDX_W'((eff + 1) * i + j);
				e.last = 1'b1;
				pending_normals.push_back(e);
			end
		end
		held_x = newer_x[a]; held_y = newer_y[a]; held_z = newer_z[a];
		older_x[a] = newer_x[a]; older_y[a] = newer_y[a]; older_z[a] = newer_z[a];
		newer_x[a] = vx; newer_y[a] = vy; newer_z[a] = vz;
		if (j >= eff) begin
			col_cnt = 0;
			row_cnt = (i >= eff) ? 0 : i + 1;
		end else begin
			col_cnt = j + 1;
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_vertex(input logic signed [hgn_pkg::VTX_W-1:0] x,
		input logic signed [hgn_pkg::VTX_W-1:0] y,
		input logic signed [hgn_pkg::VTX_W-1:0] z, input bit typed, input int ex,
		input int ey, input int ez);
		int before_cnt;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			vertices_ch.valid = 1'b0;
			@(negedge clk);
		end
		vertices_ch.valid = 1'b1;
		vertices_ch.vertex_x = x;
		vertices_ch.vertex_y = y;
		vertices_ch.vertex_z = z;
		@(posedge clk);
		while (!vertices_ch.ready) @(posedge clk);
		before_cnt = pending_normals.size();
		predict_normals(int'(x), int'(y), int'(z));
		if (typed && pending_normals.size() > before_cnt) begin
			pending_normals[before_cnt].nx = hgn_pkg::NRM_W'(ex);
			pending_normals[before_cnt].ny = hgn_pkg::NRM_W'(ey);
			pending_normals[before_cnt].nz = hgn_pkg::NRM_W'(ez);
		end
		vertices_sent++;
		@(negedge clk);
	endtask

	task automatic write_side(input int v);
		vertices_ch.valid = 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = hgn_pkg::SIDE_W'(v);
		side_reg = v;
		row_cnt = 0;
		col_cnt = 0;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_phase(input int side, input int n);
		int eff, r, c, pitch, amp, kind;
		logic signed [hgn_pkg::VTX_W-1:0] x, y, z, cx, cy, cz;
		write_side(side);
		eff = side == 0 ? 1 : side;
		r = 0; c = 0;
		pitch = $urandom_range(1, 8000000 / (eff + 1));
		amp = $urandom_range(0, 4000000);
		kind = $urandom_range(0, 9);
		cx = hgn_pkg::VTX_W'($urandom);
		cy = hgn_pkg::VTX_W'($urandom);
		cz = hgn_pkg::VTX_W'($urandom);
		repeat (n) begin
			if ($urandom_range(0, 19) == 0) begin
				x = hgn_pkg::VTX_W'($urandom);
				y = hgn_pkg::VTX_W'($urandom);
				z = hgn_pkg::VTX_W'($urandom);
			end else if (kind == 0) begin
				x = cx; y = cy; z = cz;
			end else begin
				x = hgn_pkg::VTX_W'(c * pitch + int'($urandom_range(0, 255)) - 128);
				y = hgn_pkg::VTX_W'(r * pitch + int'($urandom_range(0, 255)) - 128);
				z = hgn_pkg::VTX_W'(int'($urandom_range(0, 2 * amp)) - amp);
			end
			send_vertex(x, y, z, 1'b0, 0, 0, 0);
			if (c >= eff) begin
				c = 0;
				r = r >= eff ? 0 : r + 1;
			end else begin
				c++;
			end
		end
	endtask

	always @(negedge clk) begin
		normals_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		normal_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d normals outstanding", cycles,
				pending_normals.size());
			$display("heightfield_grid_normals_top_tb: FAIL");
			$finish;
		end else if (arst_n && normals_ch.valid && normals_ch.ready) begin
			normals_seen++;
			if (pending_normals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected normal idx=%0d", normals_ch.vertex_index);
			end else begin
				e = pending_normals.pop_front();
				if (normals_ch.normal_x !== e.nx || normals_ch.normal_y !== e.ny ||
					normals_ch.normal_z !== e.nz || normals_ch.vertex_index !== e.idx ||
					normals_ch.last_of_item !== e.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp n=(%0d,%0d,%0d) idx=%0d last=%0b",
							$signed(e.nx), $signed(e.ny), $signed(e.nz), e.idx, e.last);
						$display("         got n=(%0d,%0d,%0d) idx=%0d last=%0b",
							normals_ch.normal_x, normals_ch.normal_y, normals_ch.normal_z,
							normals_ch.vertex_index, normals_ch.last_of_item);
					end
				end
			end
		end
	end

	initial begin
		dir_row_t dir_tab [$];
		int n;
		cycles = 0; mismatches = 0; normals_seen = 0; vertices_sent = 0; interior_seen = 0;
		send_gap_pct = 17;
		recv_stall_pct = 63;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		vertices_ch.valid = 1'b0;
		vertices_ch.vertex_x = '0;
		vertices_ch.vertex_y = '0;
		vertices_ch.vertex_z = '0;
		normals_ch.ready = 1'b0;
		side_reg = int'(hgn_pkg::SIDE_RESET);
		row_cnt = 0; col_cnt = 0;
		held_x = 0; held_y = 0; held_z = 0;
		for (int k = 0; k < LINE_DEPTH; k++) begin
			older_x[k] = 0; older_y[k] = 0; older_z[k] = 0;
			newer_x[k] = 0; newer_y[k] = 0; newer_z[k] = 0;
		end

		dir_tab = '{
			// first row at reset side
			'{0, VMAX, VMAX, VMAX, 0, 0, 0, 0},
			'{1, 2, 0, 0, 0, 0, 0, 0},
			// flat plane: center normal points down
			'{0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 256, 0, 0, 0, 0, 0, 0},
			'{0, 512, 0, 0, 0, 0, 0, 0},
			'{0, 0, 256, 0, 1, 0, 0, 16384},
			'{0, 256, 256, 0, 1, 0, 0, 16384},
			'{0, 512, 256, 0, 1, 0, 0, 16384},
			'{0, 0, 512, 0, 1, 0, 0, 16384},
			'{0, 256, 512, 0, 1, 0, 0, -16384},
			'{0, 512, 512, 0, 1, 0, 0, 16384},
			// degenerate grid: zero-length cross product
			'{0, 3, 3, 3, 0, 0, 0, 0},
			'{0, 3, 3, 3, 0, 0, 0, 0},
			'{0, 3, 3, 3, 0, 0, 0, 0},
			'{0, 3, 3, 3, 0, 0, 0, 0},
			'{0, 3, 3, 3, 0, 0, 0, 0},
			'{0, 3, 3, 3, 0, 0, 0, 0},
			'{0, 3, 3, 3, 0, 0, 0, 0},
			'{0, 3, 3, 3, 1, 0, 0, 16384},
			'{0, 3, 3, 3, 0, 0, 0, 0},
			// extreme coordinates
			'{0, VMAX, VMAX, VMAX, 0, 0, 0, 0},
			'{0, VMAX, VMAX, VMAX, 0, 0, 0, 0},
			'{0, VMAX, VMAX, VMAX, 0, 0, 0, 0},
			'{0, VMIN, VMIN, VMAX, 0, 0, 0, 0},
			'{0, 0, 0, 0, 0, 0, 0, 0},
			'{0, VMAX, VMIN, VMIN, 0, 0, 0, 0},
			'{0, VMIN, VMAX, VMIN, 0, 0, 0, 0},
			'{0, VMIN, VMAX, VMIN, 0, 0, 0, 0},
			'{0, VMIN, VMAX, VMIN, 0, 0, 0, 0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[k]) begin
			if (dir_tab[k].cfg)
				write_side(dir_tab[k].x);
			else
				send_vertex(hgn_pkg::VTX_W'(dir_tab[k].x), hgn_pkg::VTX_W'(dir_tab[k].y),
					hgn_pkg::VTX_W'(dir_tab[k].z), dir_tab[k].typed,
					dir_tab[k].ex, dir_tab[k].ey, dir_tab[k].ez);
		end

		for (int mode = 0; mode < 3; mode++) begin
			send_gap_pct   = mode == 0 ? 17 : (mode == 1 ? 63 : 0);
			recv_stall_pct = mode == 0 ? 63 : (mode == 1 ? 17 : 0);
			n = vertices_sent;
			if (mode == 0) begin
				random_phase(0, 8);
				random_phase(1, 8);
			end
			if (mode == 1)
				random_phase(255, 560);
			while (vertices_sent - n < (mode == 1 ? 600 : 250)) begin
				int s;
				s = $urandom_range(1, 12);
				random_phase(s, (s + 1) * (s + 1) * $urandom_range(1, 2) + $urandom_range(0, 3));
			end
		end
		write_side(255);
		vertices_ch.valid = 1'b0;

		while (pending_normals.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d vertices, %0d normals (%0d interior), grid sides 0..255",
			vertices_sent, normals_seen, interior_seen);
		$display("three handshake pressure modes, %0d mismatches", mismatches);
		if (mismatches == 0 && pending_normals.size() == 0)
			$display("heightfield_grid_normals_top_tb: PASS");
		else
			$display("heightfield_grid_normals_top_tb: FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/hgn_pkg.sv
src/hgn_vertex_if.sv
src/hgn_normal_if.sv
src/hgn_ram.sv
src/hgn_ctrl.sv
src/hgn_dp.sv
src/heightfield_grid_normals_top.sv
verif/heightfield_grid_normals_top_tb.sv
